>>> hw/rtl/bia_pkg.sv
package bia_pkg;

	// Width of the index fields and of the counters.
	localparam int unsigned IDX_W = 12;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned CFG_W = 13;

	// Highest index that the 12-bit index fields can reach, plus one.
	localparam int unsigned INDEX_REACH = 4096;

	// Request codes.
	localparam logic [2:0] REQ_ALLOC_INODE = 3'd0;
	localparam logic [2:0] REQ_ALLOC_BLOCK = 3'd1;
	localparam logic [2:0] REQ_FREE_INODE  = 3'd2;
	localparam logic [2:0] REQ_FREE_BLOCK  = 3'd3;
	localparam logic [2:0] REQ_STATUS      = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_DATA_START   = 1'b0;
	localparam logic CFG_TOTAL_BLOCKS = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [IDX_W-1:0] DATA_START_RST   = 12'd19;
	localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 13'd4077;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [IDX_W-1:0] item_index;
	} bia_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic             success;
		logic [CNT_W-1:0] inodes_in_use;
		logic [CNT_W-1:0] blocks_in_use;
		logic [CNT_W-1:0] blocks_free;
	} bia_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESP
	} bia_state_t;

endpackage

>>> hw/rtl/bitmap_inode_block_allocator.sv
// First-fit allocator for two free bitmaps, one for inodes and one for disk blocks.
// A request is taken on start while busy is low: allocate inode, allocate block,
// free inode, free block or status query. Exactly one response follows on rsp,
// shown for a single cycle with done high; the receiver cannot hold it off, so
// it must sample rsp whenever done is high. Every response carries the counters
// as they stand after the request, and blocks_free derived from them.
// Each map lives in a memory of MAP_BITS / WORD_BITS words, read one word a cycle
// through a single shared scan unit (mask, priority encode, offset compare).
// Status queries, unknown codes and rejected frees skip the scan and go straight
// to the response step. Allocations and frees walk the words from word 0 at one
// word per cycle until the target word. Block searches also walk from word 0
// and mask off bits below the data region.
// After arst_n releases, the block sweeps both memories to zero, one word per
// cycle, holding busy high meanwhile.
// Configuration writes through cfg_we / cfg_index / cfg_wdata take effect at
// once and are expected only while the block is idle.
module bitmap_inode_block_allocator #(
	parameter int unsigned MAP_BITS  = 4096,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bia_pkg::bia_req_t               req,
	output logic                            done,
	output bia_pkg::bia_rsp_t               rsp,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [bia_pkg::CFG_W-1:0]       cfg_wdata
);
	import bia_pkg::*;

	// Number of words in each map and the widths that follow from it.
	localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BW        = $clog2(WORD_BITS);
	// Indices searched stay below both the map size and the index reach.
	localparam int unsigned LIMIT     = (MAP_BITS < INDEX_REACH) ? MAP_BITS : INDEX_REACH;
	// Bit base of a word; the scan runs at most two words past LIMIT.
	localparam int unsigned BASE_W    = 14;
	localparam int unsigned DW        = BASE_W + 1;

	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);

	// The two bitmap memories, one bit per index, set means allocated.
	logic [WORD_BITS-1:0] inode_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] block_mem [MAP_WORDS];

	bia_state_t state_q, state_d;

	bia_req_t             req_q;
	logic [IDX_W-1:0]     key_q;
	logic [IDX_W-1:0]     drs_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     inode_cnt_q;
	logic [CNT_W-1:0]     block_cnt_q;

	logic [WA_W-1:0]      clr_word_q;
	logic [WA_W-1:0]      rd_word_q;
	logic [BASE_W-1:0]    rd_base_q;
	logic                 ev_vld_s1;
	logic [BASE_W-1:0]    ev_base_s1;
	logic [WA_W-1:0]      ev_addr_s1;
	logic [WORD_BITS-1:0] inode_rd_q;
	logic [WORD_BITS-1:0] block_rd_q;

	logic [WORD_BITS-1:0] hit_word_q;
	logic [WA_W-1:0]      hit_addr_q;
	logic                 flip_q;
	logic [IDX_W-1:0]     granted_q;
	logic                 success_q;

	logic                 done_q;
	bia_rsp_t             rsp_q;

	// Control from the sequencer.
	logic                 accept;
	logic                 rd_en;
	logic                 mem_we;
	logic                 scan_enter;
	logic                 quick_ok;
	logic                 is_alloc;
	logic                 is_inode;

	// Scan unit outputs.
	logic [WORD_BITS-1:0] word;
	logic signed [DW-1:0] off_s;
	logic signed [DW-1:0] lim_s;
	logic [WORD_BITS-1:0] avail;
	logic [BW-1:0]        pos;
	logic                 hit;
	logic                 last;
	logic [WORD_BITS-1:0] new_word;
	logic                 bit_set;

	logic [WA_W-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [CNT_W-1:0]     free_cnt;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_alloc = (req_q.req_type == REQ_ALLOC_INODE) || (req_q.req_type == REQ_ALLOC_BLOCK);
	assign is_inode = (req_q.req_type == REQ_ALLOC_INODE) || (req_q.req_type == REQ_FREE_INODE);
	assign word     = is_inode ? inode_rd_q : block_rd_q;

	// Shared scan unit: one word of the selected map per cycle.
	always_comb begin
		logic signed [DW-1:0] kk;
		kk      = '0;
		off_s   = $signed({3'b000, key_q}) - $signed({1'b0, ev_base_s1});
		lim_s   = $signed(DW'(LIMIT)) - $signed({1'b0, ev_base_s1});
		avail   = '0;
		pos     = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			kk       = DW'(k);
			avail[k] = !word[k] && (kk >= off_s) && (kk < lim_s);
		end
		if (is_alloc) begin
			for (int k = WORD_BITS - 1; k >= 0; k--) begin
				if (avail[k]) begin
					pos = BW'(k);
				end
			end
			hit = |avail;
		end else begin
			pos = off_s[BW-1:0];
			hit = (off_s < $signed(DW'(WORD_BITS)));
		end
		last    = (lim_s <= $signed(DW'(WORD_BITS)));
		bit_set = word[pos];
		if (is_alloc) begin
			new_word = word | (WORD_BITS'(1) << pos);
		end else begin
			new_word = word & ~(WORD_BITS'(1) << pos);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		mem_we     = 1'b0;
		scan_enter = 1'b0;
		quick_ok   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_word_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					priority case (req.req_type)
						REQ_ALLOC_INODE, REQ_ALLOC_BLOCK: begin
							scan_enter = 1'b1;
							state_d    = ST_SCAN;
						end
						REQ_FREE_INODE, REQ_FREE_BLOCK: begin
							if ({1'b0, req.item_index} < CNT_W'(LIMIT)) begin
								scan_enter = 1'b1;
								state_d    = ST_SCAN;
							end else begin
								state_d = ST_RESP;
							end
						end
						REQ_STATUS: begin
							quick_ok = 1'b1;
							state_d  = ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (ev_vld_s1 && hit) begin
					state_d = ST_UPDATE;
				end else if (ev_vld_s1 && last) begin
					state_d = ST_RESP;
				end
			end
			ST_UPDATE: begin
				mem_we  = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory ports: one write port and one registered read port per map.
	assign wr_addr = (state_q == ST_CLEAR) ? clr_word_q : hit_addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : hit_word_q;

	always_ff @(posedge clk) begin
		if (mem_we && ((state_q == ST_CLEAR) || is_inode)) begin
			inode_mem[wr_addr] <= wr_data;
		end
		if (mem_we && ((state_q == ST_CLEAR) || !is_inode)) begin
			block_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			inode_rd_q <= inode_mem[rd_word_q];
			block_rd_q <= block_mem[rd_word_q];
		end
	end

	// Control registers: configuration, counters, scan pointers, strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drs_q       <= DATA_START_RST;
			total_q     <= TOTAL_BLOCKS_RST;
			inode_cnt_q <= '0;
			block_cnt_q <= '0;
			clr_word_q  <= '0;
			rd_word_q   <= '0;
			rd_base_q   <= '0;
			ev_vld_s1   <= 1'b0;
			success_q   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DATA_START:   drs_q   <= cfg_wdata[IDX_W-1:0];
					CFG_TOTAL_BLOCKS: total_q <= cfg_wdata;
					default:          drs_q   <= drs_q;
				endcase
			end
			if ((state_q == ST_CLEAR) && (clr_word_q != LAST_WORD)) begin
				clr_word_q <= clr_word_q + WA_W'(1);
			end
			if (accept) begin
				success_q <= quick_ok;
			end
			if (scan_enter) begin
				rd_word_q <= '0;
				rd_base_q <= '0;
				ev_vld_s1 <= 1'b0;
			end else if (rd_en) begin
				if (rd_word_q != LAST_WORD) begin
					rd_word_q <= rd_word_q + WA_W'(1);
				end
				rd_base_q <= rd_base_q + BASE_W'(WORD_BITS);
				ev_vld_s1 <= !(ev_vld_s1 && (hit || last));
			end
			if (state_q == ST_UPDATE) begin
				success_q <= 1'b1;
				if (flip_q) begin
					if (req_q.req_type == REQ_ALLOC_INODE) begin
						inode_cnt_q <= inode_cnt_q + CNT_W'(1);
					end else if (req_q.req_type == REQ_ALLOC_BLOCK) begin
						block_cnt_q <= block_cnt_q + CNT_W'(1);
					end else if ((req_q.req_type == REQ_FREE_INODE) && (inode_cnt_q != '0)) begin
						inode_cnt_q <= inode_cnt_q - CNT_W'(1);
					end else if ((req_q.req_type == REQ_FREE_BLOCK) && (block_cnt_q != '0)) begin
						block_cnt_q <= block_cnt_q - CNT_W'(1);
					end
				end
			end
			done_q <= (state_q == ST_RESP);
		end
	end

	// Payload registers.
	assign free_cnt = (total_q > block_cnt_q) ? (total_q - block_cnt_q) : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req;
			granted_q <= '0;
			priority case (req.req_type)
				REQ_ALLOC_INODE: key_q <= '0;
				REQ_ALLOC_BLOCK: key_q <= drs_q;
				default:         key_q <= req.item_index;
			endcase
		end
		if (rd_en) begin
			ev_base_s1 <= rd_base_q;
			ev_addr_s1 <= rd_word_q;
		end
		if ((state_q == ST_SCAN) && ev_vld_s1 && hit) begin
			hit_word_q <= new_word;
			hit_addr_q <= ev_addr_s1;
			flip_q     <= is_alloc || bit_set;
			if (is_alloc) begin
				granted_q <= IDX_W'(ev_base_s1 + BASE_W'(pos));
			end
		end
		if (state_q == ST_RESP) begin
			rsp_q.granted_index <= success_q ? granted_q : '0;
			rsp_q.success       <= success_q;
			rsp_q.inodes_in_use <= inode_cnt_q;
			rsp_q.blocks_in_use <= block_cnt_q;
			rsp_q.blocks_free   <= free_cnt;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// A response appears only right after the response step of the sequencer.
	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RESP))
		else $error("done without a response step");

	// A failed request never reports a granted index.
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.success) |-> (rsp.granted_index == '0))
		else $error("granted index on a failed request");

	// A granted block lies inside the data region.
	a_block_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.success && (req_q.req_type == REQ_ALLOC_BLOCK))
			|-> (rsp.granted_index >= drs_q))
		else $error("block granted below the data region");

	// The counters never pass the searchable range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(inode_cnt_q <= CNT_W'(LIMIT)) && (block_cnt_q <= CNT_W'(LIMIT)))
		else $error("allocated count beyond the map");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");
`endif

endmodule
